/* hdl/assert_macros.svh */
// Assertion macros shared by the lens undistortion RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define LPU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define LPU_IMPLY(lbl, ante, cons, msg) \
	`LPU_ASSERT(lbl, (ante) |-> (cons), msg)
// Next-cycle implication.
`define LPU_NEXT(lbl, ante, cons, msg) \
	`LPU_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define LPU_ASSERT(lbl, prop, msg)
`define LPU_IMPLY(lbl, ante, cons, msg)
`define LPU_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/lpu_pkg.sv */
// Package: types, micro-program and helpers of the lens undistortion block.
`timescale 1ns / 1ps
package lpu_pkg;

	localparam int LPU_MAX_ITER  = 10;
	localparam int LPU_RAM_DEPTH = 16;
	localparam int LPU_RAM_WIDTH = 32;

	localparam logic [31:0] Q_ONE = 32'h1000_0000;

	typedef enum logic [3:0] {
		OP_QMUL, OP_QADD, OP_QSUB, OP_DBL, OP_INV, OP_NORM,
		OP_PIXE, OP_SQ, OP_CONV, OP_OUTP
	} op_t;

	typedef enum logic [2:0] {
		B_RAM, B_K1, B_K2, B_K3, B_P1, B_P2, B_ONE, B_ZERO
	} bsel_t;

	typedef enum logic {AX_X, AX_Y} axis_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_FOCAL_X, REG_FOCAL_Y, REG_PRINCIPAL, REG_K1,
		REG_K2, REG_P1, REG_P2, REG_K3
	} reg_idx_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] dst;
		logic [3:0] a;
		logic [3:0] b;
		bsel_t      bsel;
		axis_t      axis;
	} uop_t;

	typedef struct packed {
		logic [31:0]        fx;
		logic [31:0]        fy;
		logic [15:0]        cx;
		logic [15:0]        cy;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		logic signed [31:0] k3;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
	} cfg_t;

	typedef struct packed {
		logic [24:0] num_hi;
		logic [31:0] den;
		logic        neg;
	} div_req_t;

	// scratch slots
	localparam logic [3:0] R_X0 = 4'd0;
	localparam logic [3:0] R_Y0 = 4'd1;
	localparam logic [3:0] R_X  = 4'd2;
	localparam logic [3:0] R_Y  = 4'd3;
	localparam logic [3:0] T4   = 4'd4;
	localparam logic [3:0] T5   = 4'd5;
	localparam logic [3:0] T6   = 4'd6;
	localparam logic [3:0] T7   = 4'd7;
	localparam logic [3:0] T8   = 4'd8;
	localparam logic [3:0] T9   = 4'd9;
	localparam logic [3:0] T10  = 4'd10;
	localparam logic [3:0] T11  = 4'd11;
	localparam logic [3:0] T12  = 4'd12;
	localparam logic [3:0] T13  = 4'd13;
	localparam logic [3:0] T14  = 4'd14;

	localparam logic [5:0] PC_FIRST = 6'd0;
	localparam logic [5:0] PC_LOOP  = 6'd4;
	localparam logic [5:0] PC_EPI   = 6'd62;
	localparam logic [5:0] PC_LAST  = 6'd63;

	function automatic uop_t mk(input op_t op, input logic [3:0] dst,
			input logic [3:0] a, input logic [3:0] b, input bsel_t bsel,
			input axis_t axis);
		uop_t u;
		u.op = op;
		u.dst = dst;
		u.a = a;
		u.b = b;
		u.bsel = bsel;
		u.axis = axis;
		return u;
	endfunction

	// micro-program: prologue, one undistortion pass, epilogue
	function automatic uop_t lpu_uop(input logic [5:0] pc);
		uop_t u;
		unique case (pc)
			6'd0:  u = mk(OP_NORM, R_X0, R_X0, R_X0, B_RAM, AX_X);
			6'd1:  u = mk(OP_NORM, R_Y0, R_Y0, R_Y0, B_RAM, AX_Y);
			6'd2:  u = mk(OP_QADD, R_X, R_X0, R_X0, B_ZERO, AX_X);
			6'd3:  u = mk(OP_QADD, R_Y, R_Y0, R_Y0, B_ZERO, AX_X);
			6'd4:  u = mk(OP_QMUL, T4, R_X, R_X, B_RAM, AX_X);
			6'd5:  u = mk(OP_QMUL, T5, R_Y, R_Y, B_RAM, AX_X);
			6'd6:  u = mk(OP_QADD, T6, T4, T5, B_RAM, AX_X);
			6'd7:  u = mk(OP_QMUL, T7, T6, T6, B_K3, AX_X);
			6'd8:  u = mk(OP_QADD, T7, T7, T7, B_K2, AX_X);
			6'd9:  u = mk(OP_QMUL, T7, T7, T6, B_RAM, AX_X);
			6'd10: u = mk(OP_QADD, T7, T7, T7, B_K1, AX_X);
			6'd11: u = mk(OP_QMUL, T7, T7, T6, B_RAM, AX_X);
			6'd12: u = mk(OP_QADD, T7, T7, T7, B_ONE, AX_X);
			6'd13: u = mk(OP_INV, T7, T7, T7, B_RAM, AX_X);
			6'd14: u = mk(OP_QMUL, T8, R_X, R_Y, B_RAM, AX_X);
			6'd15: u = mk(OP_DBL, T8, T8, T8, B_RAM, AX_X);
			6'd16: u = mk(OP_DBL, T9, T4, T4, B_RAM, AX_X);
			6'd17: u = mk(OP_QADD, T9, T6, T9, B_RAM, AX_X);
			6'd18: u = mk(OP_DBL, T10, T5, T5, B_RAM, AX_X);
			6'd19: u = mk(OP_QADD, T10, T6, T10, B_RAM, AX_X);
			6'd20: u = mk(OP_QMUL, T11, T8, T8, B_P1, AX_X);
			6'd21: u = mk(OP_QMUL, T12, T9, T9, B_P2, AX_X);
			6'd22: u = mk(OP_QADD, T11, T11, T12, B_RAM, AX_X);
			6'd23: u = mk(OP_QMUL, T12, T10, T10, B_P1, AX_X);
			6'd24: u = mk(OP_QMUL, T13, T8, T8, B_P2, AX_X);
			6'd25: u = mk(OP_QADD, T12, T12, T13, B_RAM, AX_X);
			6'd26: u = mk(OP_QSUB, T13, R_X0, T11, B_RAM, AX_X);
			6'd27: u = mk(OP_QMUL, R_X, T13, T7, B_RAM, AX_X);
			6'd28: u = mk(OP_QSUB, T13, R_Y0, T12, B_RAM, AX_X);
			6'd29: u = mk(OP_QMUL, R_Y, T13, T7, B_RAM, AX_X);
			6'd30: u = mk(OP_QMUL, T4, R_X, R_X, B_RAM, AX_X);
			6'd31: u = mk(OP_QMUL, T5, R_Y, R_Y, B_RAM, AX_X);
			6'd32: u = mk(OP_QADD, T6, T4, T5, B_RAM, AX_X);
			6'd33: u = mk(OP_QMUL, T9, T6, T6, B_RAM, AX_X);
			6'd34: u = mk(OP_QMUL, T10, T9, T6, B_RAM, AX_X);
			6'd35: u = mk(OP_QMUL, T8, R_X, R_Y, B_RAM, AX_X);
			6'd36: u = mk(OP_DBL, T8, T8, T8, B_RAM, AX_X);
			6'd37: u = mk(OP_DBL, T11, T4, T4, B_RAM, AX_X);
			6'd38: u = mk(OP_QADD, T11, T6, T11, B_RAM, AX_X);
			6'd39: u = mk(OP_DBL, T12, T5, T5, B_RAM, AX_X);
			6'd40: u = mk(OP_QADD, T12, T6, T12, B_RAM, AX_X);
			6'd41: u = mk(OP_QMUL, T13, T6, T6, B_K1, AX_X);
			6'd42: u = mk(OP_QADD, T13, T13, T13, B_ONE, AX_X);
			6'd43: u = mk(OP_QMUL, T14, T9, T9, B_K2, AX_X);
			6'd44: u = mk(OP_QADD, T13, T13, T14, B_RAM, AX_X);
			6'd45: u = mk(OP_QMUL, T14, T10, T10, B_K3, AX_X);
			6'd46: u = mk(OP_QADD, T13, T13, T14, B_RAM, AX_X);
			6'd47: u = mk(OP_QMUL, T4, R_X, T13, B_RAM, AX_X);
			6'd48: u = mk(OP_QMUL, T5, T8, T8, B_P1, AX_X);
			6'd49: u = mk(OP_QADD, T4, T4, T5, B_RAM, AX_X);
			6'd50: u = mk(OP_QMUL, T5, T11, T11, B_P2, AX_X);
			6'd51: u = mk(OP_QADD, T4, T4, T5, B_RAM, AX_X);
			6'd52: u = mk(OP_QMUL, T5, R_Y, T13, B_RAM, AX_X);
			6'd53: u = mk(OP_QMUL, T9, T12, T12, B_P1, AX_X);
			6'd54: u = mk(OP_QADD, T5, T5, T9, B_RAM, AX_X);
			6'd55: u = mk(OP_QMUL, T9, T8, T8, B_P2, AX_X);
			6'd56: u = mk(OP_QADD, T5, T5, T9, B_RAM, AX_X);
			6'd57: u = mk(OP_PIXE, T4, T4, T4, B_RAM, AX_X);
			6'd58: u = mk(OP_PIXE, T5, T5, T5, B_RAM, AX_Y);
			6'd59: u = mk(OP_SQ, T4, T4, T4, B_RAM, AX_X);
			6'd60: u = mk(OP_SQ, T5, T5, T5, B_RAM, AX_X);
			6'd61: u = mk(OP_CONV, T4, T4, T5, B_RAM, AX_X);
			6'd62: u = mk(OP_OUTP, T4, R_X, R_X, B_RAM, AX_X);
			6'd63: u = mk(OP_OUTP, T5, R_Y, R_Y, B_RAM, AX_Y);
			default: u = mk(OP_OUTP, T5, R_Y, R_Y, B_RAM, AX_Y);
		endcase
		return u;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'h7fff_ffff;
		else if (v < -66'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* hdl/lpu_ram.sv */
// Generic scratch RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module lpu_ram
	import lpu_pkg::*;
#(
	parameter int WIDTH = LPU_RAM_WIDTH,
	parameter int DEPTH = LPU_RAM_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wr_addr] <= wr_data;
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

/* hdl/lpu_div.sv */
// Radix-2 restoring divider with signed, saturated 32-bit quotient.
`timescale 1ns / 1ps
module lpu_div
	import lpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  div_req_t    req,
	output logic        busy,
	output logic        done,
	output logic [31:0] quo
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q, den_q, quo_q;
	logic        neg_q, ovf_q;
	logic [32:0] rem2;
	logic        qbit;
	logic [31:0] rem_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q != 6'd0)
				cnt_q <= cnt_q - 6'd1;
			else
				busy_q <= 1'b0;
		end
	end

	assign rem2    = {rem_q, 1'b0};
	assign qbit    = rem2 >= {1'b0, den_q};
	assign rem_nxt = qbit ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];

	// quotient >= 2^32 is flagged up front; only 32 quotient bits are formed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {7'd0, req.num_hi};
			den_q <= req.den;
			neg_q <= req.neg;
			ovf_q <= {7'd0, req.num_hi} >= req.den;
			quo_q <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[30:0], qbit};
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == 6'd0);

	always_comb begin
		priority if (ovf_q)
			quo = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
		else if (neg_q)
			quo = (quo_q > 32'h8000_0000) ? 32'h8000_0000 : (~quo_q + 32'd1);
		else
			quo = quo_q[31] ? 32'h7fff_ffff : quo_q;
	end

endmodule

/* hdl/lpu_alu.sv */
// Shared arithmetic unit: one 33x33 multiplier, adders, rounding and saturation.
`timescale 1ns / 1ps
module lpu_alu
	import lpu_pkg::*;
(
	input  uop_t        uop,
	input  cfg_t        cfg,
	input  logic [15:0] px,
	input  logic [15:0] py,
	input  logic [31:0] a,
	input  logic [31:0] b_ram,
	output logic [31:0] result,
	output logic        conv,
	output logic [13:0] pix_out,
	output div_req_t    div_req
);

	logic [31:0]        bv;
	logic [31:0]        f_raw, f_eff;
	logic [15:0]        c, p;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod, qm, pr, pix12, err, errmag, orr;
	logic signed [65:0] sum;
	logic signed [16:0] diff;
	logic [15:0]        dmag;

	always_comb begin
		unique case (uop.bsel)
			B_RAM:  bv = b_ram;
			B_K1:   bv = cfg.k1;
			B_K2:   bv = cfg.k2;
			B_K3:   bv = cfg.k3;
			B_P1:   bv = cfg.p1;
			B_P2:   bv = cfg.p2;
			B_ONE:  bv = Q_ONE;
			B_ZERO: bv = '0;
			default: bv = '0;
		endcase
	end

	assign f_raw = (uop.axis == AX_Y) ? cfg.fy : cfg.fx;
	assign f_eff = (f_raw == 32'd0) ? 32'd1 : f_raw;
	assign c     = (uop.axis == AX_Y) ? cfg.cy : cfg.cx;
	assign p     = (uop.axis == AX_Y) ? py : px;

	always_comb begin
		unique case (uop.op)
			OP_PIXE, OP_OUTP: begin
				ma = {a[31], a};
				mb = {1'b0, f_eff};
			end
			OP_SQ: begin
				ma = {1'b0, a};
				mb = {1'b0, a};
			end
			default: begin
				ma = {a[31], a};
				mb = {bv[31], bv};
			end
		endcase
	end

	assign prod = ma * mb;

	// Q4.28 product, round half up
	assign qm = (prod + 66'sd134217728) >>> 28;

	// projection to Q.12 pixels
	assign pr     = (prod + 66'sd2147483648) >>> 32;
	assign pix12  = pr + $signed({42'd0, c, 8'd0});
	assign err    = pix12 - $signed({42'd0, p, 8'd0});
	assign errmag = err[65] ? -err : err;
	assign orr    = (pix12 + 66'sd2048) >>> 12;

	assign diff = $signed({1'b0, p}) - $signed({1'b0, c});
	assign dmag = diff[16] ? 16'(-diff) : diff[15:0];

	assign conv = ({1'b0, a} + {1'b0, b_ram}) < 33'h100_0000;

	always_comb begin
		sum = '0;
		unique case (uop.op)
			OP_QMUL: result = sat32(qm);
			OP_QADD: begin
				sum = $signed({{34{a[31]}}, a}) + $signed({{34{bv[31]}}, bv});
				result = sat32(sum);
			end
			OP_QSUB: begin
				sum = $signed({{34{a[31]}}, a}) - $signed({{34{bv[31]}}, bv});
				result = sat32(sum);
			end
			OP_DBL: begin
				sum = $signed({{33{a[31]}}, a, 1'b0});
				result = sat32(sum);
			end
			OP_PIXE: result = (errmag >= 66'sd4096) ? 32'd4096 : errmag[31:0];
			OP_SQ:   result = prod[31:0];
			default: result = '0;
		endcase
	end

	always_comb begin
		if (orr > 66'sd8191)
			pix_out = 14'h1fff;
		else if (orr < -66'sd8192)
			pix_out = 14'h2000;
		else
			pix_out = orr[13:0];
	end

	always_comb begin
		if (uop.op == OP_NORM) begin
			div_req.num_hi = {1'b0, dmag, 8'd0};
			div_req.den    = f_eff;
			div_req.neg    = diff[16];
		end else begin
			div_req.num_hi = 25'h100_0000;
			div_req.den    = a[31] ? (~a + 32'd1) : a;
			div_req.neg    = a[31];
		end
	end

endmodule

/* hdl/lens_point_undistortion_top.sv */
// Top level: iterative Brown-Conrady point undistortion with a micro-sequenced shared unit.
//
//  channel  dir  handshake           payload (low bit first)
//  s_*      in   s_tvalid/s_tready   s_tdata: pixel_x[15:0], pixel_y[31:16]
//  m_*      out  m_tvalid/m_tready   m_tdata: corrected_x[13:0], corrected_y[27:14], 0
//  cfg_*    in   cfg_we              cfg_addr register index, cfg_data value
//
// Each micro-op runs a scratch RAM read state, then an execute and write-back state.
// Divide micro-ops (normalize, radial reciprocal) also wait in S_DIV for the radix-2 divider.
// One pass is 58 micro-ops; a request runs N passes, N = 1..MAX_ITERATIONS.
// s_tready is high only between requests; a finished result waits in the output
// register and the next request is taken meanwhile. Reset clears control and configuration.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lens_point_undistortion_top
	import lpu_pkg::*;
#(
	parameter int MAX_ITERATIONS = LPU_MAX_ITER
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_x, pixel_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // corrected_x, corrected_y, zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int IW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

	state_t         state_q, state_d;
	logic [5:0]     pc_q;
	logic [IW-1:0]  iter_q;
	logic [15:0]    px_q, py_q;
	cfg_t           cfg_q;
	logic [13:0]    ox_q, oy_q;
	logic [31:0]    m_tdata_q;
	logic           m_tvalid_q;

	uop_t           uop;
	logic [31:0]    rd_a, rd_b, alu_res, div_quo, wr_data;
	logic           conv, div_busy, div_done;
	logic [13:0]    pix_out;
	div_req_t       div_req;
	logic           is_div, last_pass;
	logic           accept, ram_we, div_start, exec_step, out_load;

	assign uop       = lpu_uop(pc_q);
	assign is_div    = (uop.op == OP_INV) || (uop.op == OP_NORM);
	assign last_pass = iter_q == IW'(MAX_ITERATIONS - 1);

	// --- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_READ;
			S_READ: state_d = S_EXEC;
			S_EXEC: begin
				priority if (is_div)
					state_d = S_DIV;
				else if (pc_q == PC_LAST)
					state_d = S_OUT;
				else
					state_d = S_READ;
			end
			S_DIV: if (div_done) state_d = S_READ;
			S_OUT: if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// --- control outputs
	always_comb begin
		s_tready  = 1'b0;
		exec_step = 1'b0;
		div_start = 1'b0;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		wr_data   = alu_res;
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_READ: ;
			S_EXEC: begin
				div_start = is_div;
				exec_step = !is_div;
				ram_we    = !is_div && (uop.op != OP_CONV) && (uop.op != OP_OUTP);
			end
			S_DIV: begin
				ram_we  = div_done;
				wr_data = div_quo;
			end
			S_OUT: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// --- sequencer: program counter and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_FIRST;
			iter_q <= '0;
		end else if (accept) begin
			pc_q   <= PC_FIRST;
			iter_q <= '0;
		end else if (exec_step) begin
			if (uop.op == OP_CONV) begin
				// early exit on sub-pixel reprojection error
				if (conv || last_pass) begin
					pc_q <= PC_EPI;
				end else begin
					pc_q   <= PC_LOOP;
					iter_q <= iter_q + IW'(1);
				end
			end else begin
				pc_q <= pc_q + 6'd1;
			end
		end else if (state_q == S_DIV && div_done) begin
			pc_q <= pc_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= s_tdata[15:0];
			py_q <= s_tdata[31:16];
		end
		if (exec_step && uop.op == OP_OUTP) begin
			if (uop.axis == AX_Y)
				oy_q <= pix_out;
			else
				ox_q <= pix_out;
		end
	end

	// --- configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fx <= 32'd32768000;
			cfg_q.fy <= 32'd32768000;
			cfg_q.cx <= '0;
			cfg_q.cy <= '0;
			cfg_q.k1 <= '0;
			cfg_q.k2 <= '0;
			cfg_q.k3 <= '0;
			cfg_q.p1 <= '0;
			cfg_q.p2 <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_FOCAL_X:   cfg_q.fx <= cfg_data;
				REG_FOCAL_Y:   cfg_q.fy <= cfg_data;
				REG_PRINCIPAL: begin
					cfg_q.cx <= cfg_data[31:16];
					cfg_q.cy <= cfg_data[15:0];
				end
				REG_K1: cfg_q.k1 <= cfg_data;
				REG_K2: cfg_q.k2 <= cfg_data;
				REG_P1: cfg_q.p1 <= cfg_data;
				REG_P2: cfg_q.p2 <= cfg_data;
				REG_K3: cfg_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// --- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= {4'd0, oy_q, ox_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// --- datapath
	lpu_ram #(
		.WIDTH(LPU_RAM_WIDTH),
		.DEPTH(LPU_RAM_DEPTH)
	) u_ram (
		.clk      (clk),
		.we       (ram_we),
		.wr_addr  (uop.dst),
		.wr_data  (wr_data),
		.rd_addr_a(uop.a),
		.rd_addr_b(uop.b),
		.rd_data_a(rd_a),
		.rd_data_b(rd_b)
	);

	lpu_alu u_alu (
		.uop    (uop),
		.cfg    (cfg_q),
		.px     (px_q),
		.py     (py_q),
		.a      (rd_a),
		.b_ram  (rd_b),
		.result (alu_res),
		.conv   (conv),
		.pix_out(pix_out),
		.div_req(div_req)
	);

	lpu_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.req   (div_req),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	// --- checks
	`LPU_NEXT(a_accept_starts, accept, state_q == S_READ && pc_q == PC_FIRST, "request did not start program")
	`LPU_ASSERT(a_iter_range, iter_q <= IW'(MAX_ITERATIONS - 1), "pass counter out of range")
	`LPU_IMPLY(a_div_wait, state_q == S_DIV, div_busy, "waiting on idle divider")
	`LPU_NEXT(a_out_load, out_load, m_tvalid, "result not presented")

endmodule
